[rtl/core/adls_pkg.sv]
// Shared types and constants for the antialiased dashed line stepper.
// No dependencies; imported by every module in rtl/core.
package adls_pkg;

  localparam int COORD_BITS   = 12;
  localparam int FRAC_BITS    = 8;
  localparam int COLOR_BITS   = 32;
  localparam int PATTERN_BITS = 32;
  localparam int PAT_IDX_BITS = $clog2(PATTERN_BITS);
  localparam int DIV_CNT_BITS = $clog2(FRAC_BITS);
  localparam int RGB_BITS     = COLOR_BITS - FRAC_BITS;

  localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS + PATTERN_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 4 * COORD_BITS + 2 * COLOR_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic div_last;
  } dp_sts_t;

  typedef struct packed {
    logic                  main_valid;
    logic [COORD_BITS-1:0] main_x;
    logic [COORD_BITS-1:0] main_y;
    logic [COLOR_BITS-1:0] main_color;
    logic                  extra_valid;
    logic [COORD_BITS-1:0] extra_x;
    logic [COORD_BITS-1:0] extra_y;
    logic [COLOR_BITS-1:0] extra_color;
    logic                  last_step;
  } result_t;

endpackage

[rtl/core/adls_ctrl.sv]
// Sequencer for the line stepper: accepts beats, runs the coverage divide,
// hands each finished position to the output register. Uses adls_pkg.
module adls_ctrl
  import adls_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  cmd_t    in_cmd,
  input  logic    out_free,
  input  dp_sts_t sts,
  output logic    in_tready,
  output dp_cmd_t dp_cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    dp_cmd    = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_cmd == CMD_LOAD) begin
            dp_cmd.load = 1'b1;
          end else if (sts.active) begin
            dp_cmd.div_init = 1'b1;
            state_nxt       = S_DIV;
          end
          // a step with no live line is dropped
        end
      end
      S_DIV: begin
        dp_cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          dp_cmd.emit = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[rtl/core/adls_datapath.sv]
// Line state, incremental minor-axis stepping and a shift-subtract divider
// for the 8-bit coverage fraction. Uses adls_pkg; driven by adls_ctrl.
module adls_datapath
  import adls_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 dp_cmd,
  input  logic [COORD_BITS-1:0]   start_x,
  input  logic [COORD_BITS-1:0]   start_y,
  input  logic [COORD_BITS-1:0]   end_x,
  input  logic [COORD_BITS-1:0]   end_y,
  input  logic [COLOR_BITS-1:0]   line_color,
  input  logic [PATTERN_BITS-1:0] dash_pattern,
  output dp_sts_t                 sts,
  output result_t                 res
);

  // line state
  logic                    active_r;
  logic [COORD_BITS-1:0]   ind_r, major_r, minor_r, err_r, quo_r, org_x_r, org_y_r;
  logic                    steep_r, neg_r;
  logic [COLOR_BITS-1:0]   color_r;
  logic [PATTERN_BITS-1:0] pattern_r;

  // divider
  logic [COORD_BITS-1:0]   rem_r;
  logic [FRAC_BITS-1:0]    num_lo_r;
  logic [FRAC_BITS-1:0]    frac_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;

  // load-time geometry
  logic [COORD_BITS-1:0]   dx, dy;
  logic                    neg_ld;

  assign dx     = (start_x > end_x) ? start_x - end_x : end_x - start_x;
  assign dy     = (start_y > end_y) ? start_y - end_y : end_y - start_y;
  assign neg_ld = ((start_x < end_x) && (end_y < start_y)) ||
                  ((end_x < start_x) && (start_y < end_y));

  // err * 255 as (err << 8) - err
  logic [COORD_BITS+FRAC_BITS-1:0] num;
  assign num = {err_r, {FRAC_BITS{1'b0}}} - {{FRAC_BITS{1'b0}}, err_r};

  logic [COORD_BITS:0] trial;
  logic                fit;
  assign trial = {rem_r, num_lo_r[FRAC_BITS-1]};
  assign fit   = trial >= {1'b0, major_r};

  logic [COORD_BITS:0] err_sum;
  logic                last;
  assign err_sum = {1'b0, err_r} + {1'b0, minor_r};
  assign last    = ind_r >= major_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (dp_cmd.load) begin
        active_r <= !((dx == '0) && (dy == '0));
      end else if (dp_cmd.emit && last) begin
        active_r <= 1'b0;
      end
      if (dp_cmd.div_init) begin
        cnt_r <= '0;
      end else if (dp_cmd.div_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      steep_r   <= dy > dx;
      major_r   <= (dy > dx) ? dy : dx;
      minor_r   <= (dy > dx) ? dx : dy;
      neg_r     <= neg_ld;
      org_x_r   <= (start_x < end_x) ? start_x : end_x;
      org_y_r   <= (start_y < end_y) ? start_y : end_y;
      color_r   <= line_color;
      pattern_r <= dash_pattern;
      ind_r     <= '0;
      err_r     <= '0;
      quo_r     <= '0;
    end else if (dp_cmd.emit && !last) begin
      ind_r <= ind_r + 1'b1;
      if (err_sum >= {1'b0, major_r}) begin
        err_r <= COORD_BITS'(err_sum - {1'b0, major_r});
        quo_r <= quo_r + 1'b1;
      end else begin
        err_r <= COORD_BITS'(err_sum);
      end
    end

    // quotient fits in FRAC_BITS because err < major
    if (dp_cmd.div_init) begin
      rem_r    <= num[COORD_BITS+FRAC_BITS-1:FRAC_BITS];
      num_lo_r <= num[FRAC_BITS-1:0];
      frac_r   <= '0;
    end else if (dp_cmd.div_step) begin
      rem_r    <= fit ? COORD_BITS'(trial - {1'b0, major_r}) : COORD_BITS'(trial);
      num_lo_r <= {num_lo_r[FRAC_BITS-2:0], 1'b0};
      frac_r   <= {frac_r[FRAC_BITS-2:0], fit};
    end
  end

  assign sts.active   = active_r;
  assign sts.div_last = (cnt_r == DIV_CNT_BITS'(FRAC_BITS - 1));

  // position formatting
  logic [COORD_BITS-1:0] sub, nsub, mx, my, ex, ey;
  logic                  gate, frac_nz;

  assign sub     = neg_r ? minor_r - quo_r : quo_r;
  assign nsub    = neg_r ? sub - 1'b1 : sub + 1'b1;
  assign mx      = steep_r ? org_x_r + sub  : org_x_r + ind_r;
  assign my      = steep_r ? org_y_r + ind_r : org_y_r + sub;
  assign ex      = steep_r ? org_x_r + nsub : mx;
  assign ey      = steep_r ? my : org_y_r + nsub;
  assign gate    = pattern_r[ind_r[PAT_IDX_BITS-1:0]];
  assign frac_nz = frac_r != '0;

  always_comb begin
    res           = '0;
    res.last_step = last;
    if (gate) begin
      res.main_valid = 1'b1;
      res.main_x     = mx;
      res.main_y     = my;
      res.main_color = color_r ^ {frac_r, {RGB_BITS{1'b0}}};
      if (frac_nz) begin
        res.extra_valid = 1'b1;
        res.extra_x     = ex;
        res.extra_y     = ey;
        res.extra_color = {frac_r, color_r[RGB_BITS-1:0]};
      end
    end
  end

endmodule

[rtl/core/antialiased_dashed_line_stepper.sv]
// Top level of the antialiased dashed line stepper: stream ports, output
// register, controller and datapath. Uses adls_pkg, adls_ctrl, adls_datapath.
//
// A load beat (tuser = 0) gives no result; a line whose endpoints coincide
// is dropped. A step beat (tuser = 1) on a live line is accepted, runs
// through the shift-subtract divider that forms the coverage fraction (one
// quotient bit a cycle), and then moves the pixel pair into the output
// register. A step with no live line is dropped. The output register lets
// the next beat be accepted while a result still waits; a stalled result
// holds the datapath only while it waits to enter the output register.
// The line covers major length + 1 positions; tlast marks the final one.
module antialiased_dashed_line_stepper
  import adls_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // [0] cmd
  input  logic                     in_tuser,
  // start_x, start_y, end_x, end_y, line_color, dash_pattern (low to high)
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [0] main_valid, [1] extra_valid
  output logic [1:0]               out_tuser,
  // main_x, main_y, main_color, extra_x, extra_y, extra_color (low to high)
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic                     out_tlast
);

  localparam int SY  = COORD_BITS;
  localparam int EX  = 2 * COORD_BITS;
  localparam int EY  = 3 * COORD_BITS;
  localparam int COL = 4 * COORD_BITS;
  localparam int PAT = COL + COLOR_BITS;

  dp_cmd_t dp_cmd;
  dp_sts_t sts;
  result_t res;
  result_t out_res_r;
  logic    out_tvalid_r;
  logic    out_free;

  assign out_free = !out_tvalid_r || out_tready;

  adls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (cmd_t'(in_tuser)),
    .out_free  (out_free),
    .sts       (sts),
    .in_tready (in_tready),
    .dp_cmd    (dp_cmd)
  );

  adls_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .dp_cmd       (dp_cmd),
    .start_x      (in_tdata[SY-1:0]),
    .start_y      (in_tdata[EX-1:SY]),
    .end_x        (in_tdata[EY-1:EX]),
    .end_y        (in_tdata[COL-1:EY]),
    .line_color   (in_tdata[PAT-1:COL]),
    .dash_pattern (in_tdata[PAT+PATTERN_BITS-1:PAT]),
    .sts          (sts),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (dp_cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = {out_res_r.extra_valid, out_res_r.main_valid};
  assign out_tlast  = out_res_r.last_step;
  assign out_tdata  = OUT_DATA_BITS'({out_res_r.extra_color, out_res_r.extra_y,
                                      out_res_r.extra_x, out_res_r.main_color,
                                      out_res_r.main_y, out_res_r.main_x});

  // a new result never overwrites one that has not been taken
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.emit |-> (!out_tvalid_r || out_tready))
    else $error("result emitted over a pending beat");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.emit |=> out_tvalid)
    else $error("emitted result not presented");

  a_extra_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[1] || out_tuser[0]))
    else $error("neighbor pixel without main pixel");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.div_step || dp_cmd.div_init) |-> !(dp_cmd.load || dp_cmd.emit))
    else $error("conflicting datapath commands");

endmodule

[sim/antialiased_dashed_line_stepper_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for antialiased_dashed_line_stepper: directed lines, then random
// load/step streams with random stalls on both sides and then without, compared against a
// line-stepping predictor beat by beat. Depends on adls_pkg and the RTL under rtl/core.
module antialiased_dashed_line_stepper_tb;
  import adls_pkg::*;

  typedef logic [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = '1;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 30;
  localparam int STALL_LIMIT = 3000;

  // out_tdata field offsets
  localparam int MX_LO = 0;
  localparam int MY_LO = MX_LO + COORD_BITS;
  localparam int MC_LO = MY_LO + COORD_BITS;
  localparam int EX_LO = MC_LO + COLOR_BITS;
  localparam int EY_LO = EX_LO + COORD_BITS;
  localparam int EC_LO = EY_LO + COORD_BITS;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic                     in_tuser;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [1:0]               out_tuser;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tlast;

  antialiased_dashed_line_stepper u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // line state as the predictor tracks it
  logic        line_live;
  coord_t      pos_idx, major_len, minor_len, err_acc, minor_q, org_x, org_y;
  logic        steep, neg_slope;
  logic [31:0] color_q, pattern_q;

  result_t pixels_due[$];
  int      mismatches;
  int      useful_beats;
  bit      idle_en;
  bit      hold_req;

  function automatic logic [IN_DATA_BITS-1:0] pack_line(coord_t x1, coord_t y1, coord_t x2,
                                                        coord_t y2, logic [31:0] color,
                                                        logic [31:0] pattern);
    return {pattern, color, y2, x2, y1, x1};
  endfunction

  task automatic predict_pixels(input cmd_t c, input logic [IN_DATA_BITS-1:0] d);
    coord_t            x1, y1, x2, y2, dx, dy, sub, nsub, mx, my, ex, ey;
    logic [31:0]       prod;
    logic [7:0]        frac;
    logic [COORD_BITS:0] acc_sum;
    logic              gate, last;
    result_t           r;
    if (c == CMD_LOAD) begin
      useful_beats++;
      x1 = d[0 +: COORD_BITS];
      y1 = d[COORD_BITS +: COORD_BITS];
      x2 = d[2*COORD_BITS +: COORD_BITS];
      y2 = d[3*COORD_BITS +: COORD_BITS];
      dx = (x1 > x2) ? x1 - x2 : x2 - x1;
      dy = (y1 > y2) ? y1 - y2 : y2 - y1;
      if (dx == 0 && dy == 0) begin
        line_live = 1'b0;
      end else begin
        steep     = dy > dx;
        major_len = steep ? dy : dx;
        minor_len = steep ? dx : dy;
        neg_slope = (x1 < x2 && y2 < y1) || (x2 < x1 && y1 < y2);
        org_x     = (x1 < x2) ? x1 : x2;
        org_y     = (y1 < y2) ? y1 : y2;
        color_q   = d[4*COORD_BITS +: COLOR_BITS];
        pattern_q = d[4*COORD_BITS+COLOR_BITS +: PATTERN_BITS];
        pos_idx   = '0;
        err_acc   = '0;
        minor_q   = '0;
        line_live = 1'b1;
      end
    end else if (line_live) begin
      useful_beats++;
      prod = 32'(err_acc) * 32'd255;
      frac = 8'(prod / 32'(major_len));
      gate = pattern_q[pos_idx[4:0]];
      last = pos_idx >= major_len;
      sub  = neg_slope ? minor_len - minor_q : minor_q;
      nsub = neg_slope ? sub - 1'b1 : sub + 1'b1;
      if (steep) begin
        mx = org_x + sub;
        my = org_y + pos_idx;
        ex = org_x + nsub;
        ey = my;
      end else begin
        mx = org_x + pos_idx;
        my = org_y + sub;
        ex = mx;
        ey = org_y + nsub;
      end
      r = '0;
      if (gate) begin
        r.main_valid = 1'b1;
        r.main_x     = mx;
        r.main_y     = my;
        r.main_color = color_q ^ {frac, 24'h0};
        if (frac != 0) begin
          r.extra_valid = 1'b1;
          r.extra_x     = ex;
          r.extra_y     = ey;
          r.extra_color = {frac, color_q[RGB_BITS-1:0]};
        end
      end
      r.last_step = last;
      pixels_due.insert(pixels_due.size(), r);
      if (last) begin
        line_live = 1'b0;
      end else begin
        pos_idx = pos_idx + 1'b1;
        acc_sum = {1'b0, err_acc} + minor_len;
        if (acc_sum >= major_len) begin
          acc_sum = acc_sum - major_len;
          minor_q = minor_q + 1'b1;
        end
        err_acc = acc_sum[COORD_BITS-1:0];
      end
    end
  endtask

  // valid is left high after a beat so back-to-back beats need no re-raise
  task automatic send_beat(input cmd_t c, input logic [IN_DATA_BITS-1:0] d);
    int gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    predict_pixels(c, d);
  endtask

  task automatic send_steps(input int n);
    repeat (n) send_beat(CMD_STEP, IN_DATA_BITS'({$urandom(), $urandom(), $urandom(),
                                                   $urandom()}));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic coord_t nudge(coord_t c, int d);
    if ($urandom_range(0, 1)) d = -d;
    if (int'(c) + d < 0 || int'(c) + d > int'(COORD_MAX)) d = -d;
    return coord_t'(int'(c) + d);
  endfunction

  task automatic send_random_line(input int max_span);
    coord_t      x1, y1;
    int          dx, dy, steps;
    logic [31:0] pattern;
    x1 = coord_t'($urandom);
    y1 = coord_t'($urandom);
    dx = $urandom_range(0, max_span);
    dy = $urandom_range(0, max_span);
    if ($urandom_range(0, 15) == 0) begin
      dx = 0;
      dy = 0;
    end
    case ($urandom_range(0, 7))
      0:       pattern = '1;
      1:       pattern = '0;
      default: pattern = $urandom;
    endcase
    send_beat(CMD_LOAD, pack_line(x1, y1, nudge(x1, dx), nudge(y1, dy), $urandom, pattern));
    if (line_live) begin
      steps = int'(major_len) + 1;
      case ($urandom_range(0, 7))
        0: steps = $urandom_range(0, steps - 1);   // cut short, next load replaces it
        1: steps = steps + $urandom_range(1, 2);   // steps past the end are dropped
        default: ;
      endcase
    end else begin
      steps = $urandom_range(0, 1);
    end
    send_steps(steps);
  endtask

  task automatic test_directed();
    send_steps(1);                                             // no line loaded yet
    send_beat(CMD_LOAD, pack_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, '1, '1));
    send_steps(1);                                             // degenerate line dropped
    send_beat(CMD_LOAD, pack_line(12'd0, COORD_MAX, COORD_MAX, 12'd0, '0, '1));
    send_steps(2);                                             // long line, replaced below
    send_beat(CMD_LOAD, pack_line(12'd100, 12'd200, 12'd103, 12'd205, 32'h80FF00FF, '1));
    send_steps(7);                                             // steep, one extra step
    send_beat(CMD_LOAD, pack_line(COORD_MAX - 12'd5, 12'd5, COORD_MAX, 12'd2, 32'h12345678,
                                  32'h5));
    send_steps(6);                                             // shallow, negative, gated
    send_beat(CMD_LOAD, pack_line(12'd3, 12'd0, 12'd0, 12'd0, '1, '1));
    send_steps(4);                                             // flat line, zero fraction
    drain_results();
  endtask

  task automatic test_random_lines(input int target);
    int first;
    first = useful_beats;
    while (useful_beats - first < target)
      send_random_line(($urandom_range(0, 19) == 0) ? 48 : 10);
    drain_results();
  endtask

  // sink stops for a long stretch while the source keeps pushing steps
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_beat(CMD_LOAD, pack_line(12'd10, 12'd40, 12'd37, 12'd29, $urandom, $urandom));
    send_steps(28);
    while (hold_req) @(posedge clk);
    drain_results();
  endtask

  // source goes quiet mid-line until every result is back, then resumes
  task automatic test_pause_midline();
    send_beat(CMD_LOAD, pack_line(12'd2000, 12'd1000, 12'd1985, 12'd1021, $urandom,
                                  $urandom));
    send_steps(8);
    drain_results();
    send_steps(14);
    drain_results();
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic void cmp(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : pixel_check
    result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pixels_due.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        cmp("main_valid", 32'(want.main_valid), 32'(out_tuser[0]));
        cmp("main_x", 32'(want.main_x), 32'(out_tdata[MX_LO +: COORD_BITS]));
        cmp("main_y", 32'(want.main_y), 32'(out_tdata[MY_LO +: COORD_BITS]));
        cmp("main_color", want.main_color, out_tdata[MC_LO +: COLOR_BITS]);
        cmp("extra_valid", 32'(want.extra_valid), 32'(out_tuser[1]));
        cmp("extra_x", 32'(want.extra_x), 32'(out_tdata[EX_LO +: COORD_BITS]));
        cmp("extra_y", 32'(want.extra_y), 32'(out_tdata[EY_LO +: COORD_BITS]));
        cmp("extra_color", want.extra_color, out_tdata[EC_LO +: COLOR_BITS]);
        cmp("last_step", 32'(want.last_step), 32'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, quiet);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_tvalid    = 1'b0;
    in_tuser     = 1'b0;
    in_tdata     = '0;
    rst_n        = 1'b0;
    idle_en      = 1'b1;
    hold_req     = 1'b0;
    mismatches   = 0;
    useful_beats = 0;
    line_live    = 1'b0;
    pos_idx      = '0;
    major_len    = '0;
    minor_len    = '0;
    err_acc      = '0;
    minor_q      = '0;
    org_x        = '0;
    org_y        = '0;
    steep        = 1'b0;
    neg_slope    = 1'b0;
    color_q      = '0;
    pattern_q    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_lines(900);
    test_backpressure();
    test_pause_midline();
    idle_en = 1'b0;
    test_random_lines(420);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
